@@ sv/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and constants shared by the pedestrian crossing controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

   // Width of the phase timer and of the time-since-green counter
   localparam int TIMER_WIDTH = 16;
   localparam int REG_WIDTH   = 16;
   localparam int CNT_WIDTH   = 4;
   localparam int CSR_IDX_W   = 3;
   // Duration width: a duration may reach 2^TIMER_WIDTH ticks
   localparam int DUR_WIDTH   = TIMER_WIDTH + 1;
   // Width used to compare since_green against min_green_ticks
   localparam int CMP_WIDTH   = (TIMER_WIDTH > REG_WIDTH) ? TIMER_WIDTH : REG_WIDTH;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [2:0] {
      PH_GREEN       = 3'd0,
      PH_GREEN_FLASH = 3'd1,
      PH_YELLOW      = 3'd2,
      PH_RED_CLEAR   = 3'd3,
      PH_WALK        = 3'd4,
      PH_WALK_FLASH  = 3'd5,
      PH_WALKER_CLR  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      TONE_OFF = 2'd0,
      TONE_440 = 2'd1,
      TONE_330 = 2'd2
   } tone_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_GREEN  = 3'd0,
      CSR_BLINK_HALF = 3'd1,
      CSR_YELLOW     = 3'd2,
      CSR_CLEAR      = 3'd3,
      CSR_TONE_HALF  = 3'd4,
      CSR_WALK_CYC   = 3'd5,
      CSR_FLASH_CNT  = 3'd6
   } csr_idx_type;

   // Result item, last field in the lowest bit
   typedef struct packed {
      logic [2:0] phase;
      tone_type   tone_code;
      logic       walker_green;
      logic       walker_red;
      logic       car_green;
      logic       car_yellow;
      logic       car_red;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   localparam logic [REG_WIDTH-1:0] RST_MIN_GREEN  = 16'd10000;
   localparam logic [REG_WIDTH-1:0] RST_BLINK_HALF = 16'd250;
   localparam logic [REG_WIDTH-1:0] RST_YELLOW     = 16'd2000;
   localparam logic [REG_WIDTH-1:0] RST_CLEAR      = 16'd1000;
   localparam logic [REG_WIDTH-1:0] RST_TONE_HALF  = 16'd500;
   localparam logic [CNT_WIDTH-1:0] RST_WALK_CYC   = 4'd5;
   localparam logic [CNT_WIDTH-1:0] RST_FLASH_CNT  = 4'd6;

   // Segment length: zero acts as one, capped at 2^TIMER_WIDTH
   function automatic logic [DUR_WIDTH-1:0] seg_len(input logic [REG_WIDTH-1:0] r);
      logic [DUR_WIDTH-1:0] lim;
      logic [CMP_WIDTH:0]   d;
      lim = {1'b1, {TIMER_WIDTH{1'b0}}};
      d   = (r == '0) ? (CMP_WIDTH+1)'(1) : (CMP_WIDTH+1)'(r);
      if (d > (CMP_WIDTH+1)'(lim)) begin
         return lim;
      end
      return DUR_WIDTH'(d);
   endfunction

   function automatic logic [CNT_WIDTH-1:0] at_least_one(input logic [CNT_WIDTH-1:0] v);
      return (v == '0) ? CNT_WIDTH'(1) : v;
   endfunction

endpackage

@@ sv/pedestrian_crossing_controller_top.sv @@
// The result item of an accepted tick item is in the output register in the next cycle.
// One item per cycle unless the output stalls; the phase update is a single registered pass.
// The input is ready whenever the output register is empty or being taken.
// Reset (synchronous, active high) returns to car green, clears the request,
// the timers and the output valid, and loads the default register values.
// ----------------------------------------------------------------------------
// pedestrian_crossing_controller_top
// Pedestrian crossing light controller, one item per millisecond tick.
// ----------------------------------------------------------------------------
module pedestrian_crossing_controller_top
   import pcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] button, rest zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [0] car_red [1] car_yellow
                                               // [2] car_green [3] walker_red
                                               // [4] walker_green [6:5] tone_code
                                               // [9:7] phase, rest zero
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata
);

   // configuration registers
   logic [REG_WIDTH-1:0] min_green_ff, blink_half_ff, yellow_ff, clear_ff, tone_half_ff;
   logic [CNT_WIDTH-1:0] walk_cyc_ff, flash_cnt_ff;

   // controller state
   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [CNT_WIDTH-1:0]   rep_ff, rep_in;
   logic [1:0]             sub_ff, sub_in;
   logic                   request_ff, request_in;
   logic [TIMER_WIDTH-1:0] since_ff, since_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   logic accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(result_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_green_ff  <= RST_MIN_GREEN;
         blink_half_ff <= RST_BLINK_HALF;
         yellow_ff     <= RST_YELLOW;
         clear_ff      <= RST_CLEAR;
         tone_half_ff  <= RST_TONE_HALF;
         walk_cyc_ff   <= RST_WALK_CYC;
         flash_cnt_ff  <= RST_FLASH_CNT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_GREEN:  min_green_ff  <= csr_wdata;
            CSR_BLINK_HALF: blink_half_ff <= csr_wdata;
            CSR_YELLOW:     yellow_ff     <= csr_wdata;
            CSR_CLEAR:      clear_ff      <= csr_wdata;
            CSR_TONE_HALF:  tone_half_ff  <= csr_wdata;
            CSR_WALK_CYC:   walk_cyc_ff   <= csr_wdata[CNT_WIDTH-1:0];
            CSR_FLASH_CNT:  flash_cnt_ff  <= csr_wdata[CNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_type              cur_ph;
      logic [TIMER_WIDTH-1:0] cur_timer;
      logic [CNT_WIDTH-1:0]   cur_rep;
      logic [CNT_WIDTH-1:0]   rep_inc;
      logic [1:0]             cur_sub;
      logic                   req_now;
      logic                   start;
      logic [DUR_WIDTH-1:0]   dur;
      logic [DUR_WIDTH-1:0]   tick;
      logic                   seg_end;
      logic                   in_green;

      phase_in   = phase_ff;
      timer_in   = timer_ff;
      rep_in     = rep_ff;
      sub_in     = sub_ff;
      request_in = request_ff;
      since_in   = since_ff;
      result_in  = '0;

      in_green  = (phase_ff == PH_GREEN) || (phase_ff > PH_WALKER_CLR);
      req_now   = request_ff || req_tdata[0];
      start     = in_green && req_now &&
                  (CMP_WIDTH'(since_ff) > CMP_WIDTH'(min_green_ff));

      cur_ph    = start ? PH_GREEN_FLASH : phase_ff;
      cur_timer = start ? '0 : timer_ff;
      cur_rep   = start ? '0 : rep_ff;
      cur_sub   = start ? '0 : sub_ff;
      rep_inc   = cur_rep + CNT_WIDTH'(1);

      dur = seg_len(clear_ff);
      case (cur_ph)
         PH_GREEN_FLASH: begin
            result_in.car_green  = (cur_sub == 2'd0);
            result_in.walker_red = 1'b1;
            dur = seg_len(blink_half_ff);
         end
         PH_YELLOW: begin
            result_in.car_yellow = 1'b1;
            result_in.walker_red = 1'b1;
            dur = seg_len(yellow_ff);
         end
         PH_WALK: begin
            result_in.car_red      = 1'b1;
            result_in.walker_green = 1'b1;
            result_in.tone_code    = (cur_sub == 2'd0) ? TONE_440 :
                                     (cur_sub == 2'd2) ? TONE_330 : TONE_OFF;
            dur = seg_len(tone_half_ff);
         end
         PH_WALK_FLASH: begin
            result_in.car_red      = 1'b1;
            result_in.walker_green = (cur_sub == 2'd0);
            result_in.tone_code    = (cur_sub == 2'd0) ? TONE_440 : TONE_OFF;
            dur = seg_len(blink_half_ff);
         end
         default: begin
            // red clear and walker red clear
            result_in.car_red    = 1'b1;
            result_in.walker_red = 1'b1;
         end
      endcase
      result_in.phase = cur_ph;

      tick    = DUR_WIDTH'(cur_timer) + DUR_WIDTH'(1);
      seg_end = (tick >= dur);

      if (in_green && !start) begin
         // hold green, latch the press, count green time with saturation
         result_in           = '0;
         result_in.car_green  = 1'b1;
         result_in.walker_red = 1'b1;
         result_in.phase      = PH_GREEN;
         phase_in   = PH_GREEN;
         request_in = req_now;
         if (since_ff != {TIMER_WIDTH{1'b1}}) begin
            since_in = since_ff + TIMER_WIDTH'(1);
         end
      end else begin
         phase_in = cur_ph;
         timer_in = seg_end ? '0 : tick[TIMER_WIDTH-1:0];
         rep_in   = cur_rep;
         sub_in   = cur_sub;
         if (start) begin
            request_in = 1'b1;
         end
         if (seg_end) begin
            case (cur_ph)
               PH_GREEN_FLASH, PH_WALK_FLASH: begin
                  if (cur_sub == 2'd0) begin
                     sub_in = 2'd1;
                  end else begin
                     sub_in = 2'd0;
                     rep_in = rep_inc;
                     if (rep_inc >= at_least_one(flash_cnt_ff)) begin
                        phase_in = (cur_ph == PH_GREEN_FLASH) ? PH_YELLOW : PH_WALKER_CLR;
                        rep_in   = '0;
                     end
                  end
               end
               PH_YELLOW: begin
                  phase_in = PH_RED_CLEAR;
                  rep_in   = '0;
                  sub_in   = '0;
               end
               PH_RED_CLEAR: begin
                  phase_in = PH_WALK;
                  rep_in   = '0;
                  sub_in   = '0;
               end
               PH_WALK: begin
                  if (cur_sub != 2'd3) begin
                     sub_in = cur_sub + 2'd1;
                  end else begin
                     sub_in = 2'd0;
                     rep_in = rep_inc;
                     if (rep_inc >= at_least_one(walk_cyc_ff)) begin
                        phase_in = PH_WALK_FLASH;
                        rep_in   = '0;
                     end
                  end
               end
               default: begin
                  // back to car green, drop the request, restart green time
                  phase_in   = PH_GREEN;
                  rep_in     = '0;
                  sub_in     = '0;
                  request_in = 1'b0;
                  since_in   = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GREEN;
         timer_ff     <= '0;
         rep_ff       <= '0;
         sub_ff       <= '0;
         request_ff   <= 1'b0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            timer_ff   <= timer_in;
            rep_ff     <= rep_in;
            sub_ff     <= sub_in;
            request_ff <= request_in;
            since_ff   <= since_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

endmodule
